// ===== design/point_cloud_depth_splat_unit_assert.svh =====
// assertion macros for the depth splat unit
`ifndef POINT_CLOUD_DEPTH_SPLAT_UNIT_ASSERT_SVH
`define POINT_CLOUD_DEPTH_SPLAT_UNIT_ASSERT_SVH
`ifndef SYNTH
// same-cycle implication
`define PCDS_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("pcds assertion failed");
// next-cycle implication
`define PCDS_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("pcds assertion failed");
`else
`define PCDS_ASSERT_IMP(lbl, ante, cons)
`define PCDS_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

// ===== design/pcds_pkg.sv =====
package pcds_pkg;

    localparam int PIXEL_COUNT = 524288;
    localparam int ADDR_W      = $clog2(PIXEL_COUNT);
    localparam int MAX_WIDTH   = 1024;
    localparam int MAX_HEIGHT  = 512;
    localparam int DIV_STEPS   = 25;
    localparam int DIV_CNT_W   = $clog2(DIV_STEPS);
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 24;
    localparam int S_TDATA_W   = 192;
    localparam int M_TDATA_W   = 192;
    localparam int MAIN_W      = 95;
    localparam int NORMAL_W    = 48;
    localparam int COLOR_W     = 24;

    typedef enum logic [1:0] {
        ACT_SPLAT = 2'd0,
        ACT_READ  = 2'd1,
        ACT_CLEAR = 2'd2,
        ACT_SPARE = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        STAT_STORED  = 2'd0,
        STAT_BEHIND  = 2'd1,
        STAT_OUTSIDE = 2'd2,
        STAT_DONE    = 2'd3
    } status_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FOCAL_X  = 3'd0,
        CFG_FOCAL_Y  = 3'd1,
        CFG_CENTER_X = 3'd2,
        CFG_CENTER_Y = 3'd3,
        CFG_WIDTH    = 3'd4,
        CFG_HEIGHT   = 3'd5,
        CFG_MODE     = 3'd6
    } cfg_idx_t;

    typedef enum logic [3:0] {
        S_SWEEP,
        S_IDLE,
        S_DECIDE,
        S_MUL,
        S_DINIT,
        S_DIV,
        S_PROJ,
        S_INDEX,
        S_CHECK,
        S_RD,
        S_COMMIT,
        S_REJ_Z,
        S_REJ_B
    } state_t;

    typedef struct packed {
        logic [1:0]        action;
        logic [31:0]       in_x;
        logic [31:0]       in_y;
        logic [31:0]       in_z;
        logic [15:0]       in_normal_x;
        logic [15:0]       in_normal_y;
        logic [15:0]       in_normal_z;
        logic              normal_present;
        logic [23:0]       in_color;
        logic              color_present;
        logic [ADDR_W-1:0] pixel_addr;
    } item_t;

    typedef struct packed {
        logic [1:0]        status;
        logic [ADDR_W-1:0] out_pixel;
        logic [31:0]       out_x;
        logic [31:0]       out_y;
        logic [30:0]       out_depth;
        logic [15:0]       out_normal_x;
        logic [15:0]       out_normal_y;
        logic [15:0]       out_normal_z;
        logic [23:0]       out_color;
    } result_t;

    typedef struct packed {
        logic sweep;
        logic accept;
        logic mul;
        logic div_init;
        logic div_step;
        logic proj;
        logic index;
        logic rd;
        logic commit;
        logic reject;
        logic reject_bounds;
    } cmd_t;

    typedef struct packed {
        logic sweep_last;
        logic is_splat;
        logic is_ortho;
        logic z_bad;
        logic bounds_ok;
        logic out_free;
    } stat_t;

endpackage

// ===== design/pcds_ram.sv =====
module pcds_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== design/pcds_ctrl.sv =====
`include "point_cloud_depth_splat_unit_assert.svh"

module pcds_ctrl (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            in_valid,
    output logic            in_ready,
    input  pcds_pkg::stat_t st,
    output pcds_pkg::cmd_t  cmd
);

    pcds_pkg::state_t                   state_reg, state_next;
    logic [pcds_pkg::DIV_CNT_W-1:0]     div_cnt_reg, div_cnt_next;

    // state and step counter
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= pcds_pkg::S_SWEEP;
            div_cnt_reg <= '0;
        end else begin
            state_reg   <= state_next;
            div_cnt_reg <= div_cnt_next;
        end
    end

    // next state and commands
    always_comb begin
        state_next   = state_reg;
        div_cnt_next = div_cnt_reg;
        cmd          = '0;
        in_ready     = 1'b0;
        case (state_reg)
            pcds_pkg::S_SWEEP: begin
                cmd.sweep = 1'b1;
                if (st.sweep_last) begin
                    state_next = pcds_pkg::S_IDLE;
                end
            end
            pcds_pkg::S_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    cmd.accept = 1'b1;
                    state_next = pcds_pkg::S_DECIDE;
                end
            end
            pcds_pkg::S_DECIDE: begin
                if (!st.is_splat) begin
                    state_next = pcds_pkg::S_RD;
                end else if (st.z_bad) begin
                    state_next = pcds_pkg::S_REJ_Z;
                end else if (st.is_ortho) begin
                    state_next = pcds_pkg::S_PROJ;
                end else begin
                    state_next = pcds_pkg::S_MUL;
                end
            end
            pcds_pkg::S_MUL: begin
                cmd.mul    = 1'b1;
                state_next = pcds_pkg::S_DINIT;
            end
            pcds_pkg::S_DINIT: begin
                cmd.div_init = 1'b1;
                div_cnt_next = '0;
                state_next   = pcds_pkg::S_DIV;
            end
            pcds_pkg::S_DIV: begin
                cmd.div_step = 1'b1;
                if (div_cnt_reg == pcds_pkg::DIV_CNT_W'(pcds_pkg::DIV_STEPS - 1)) begin
                    state_next = pcds_pkg::S_PROJ;
                end else begin
                    div_cnt_next = div_cnt_reg + 1'b1;
                end
            end
            pcds_pkg::S_PROJ: begin
                cmd.proj   = 1'b1;
                state_next = pcds_pkg::S_INDEX;
            end
            pcds_pkg::S_INDEX: begin
                cmd.index  = 1'b1;
                state_next = pcds_pkg::S_CHECK;
            end
            pcds_pkg::S_CHECK: begin
                state_next = st.bounds_ok ? pcds_pkg::S_RD : pcds_pkg::S_REJ_B;
            end
            pcds_pkg::S_RD: begin
                cmd.rd     = 1'b1;
                state_next = pcds_pkg::S_COMMIT;
            end
            pcds_pkg::S_COMMIT: begin
                if (st.out_free) begin
                    cmd.commit = 1'b1;
                    state_next = pcds_pkg::S_IDLE;
                end
            end
            pcds_pkg::S_REJ_Z: begin
                if (st.out_free) begin
                    cmd.reject = 1'b1;
                    state_next = pcds_pkg::S_IDLE;
                end
            end
            pcds_pkg::S_REJ_B: begin
                if (st.out_free) begin
                    cmd.reject        = 1'b1;
                    cmd.reject_bounds = 1'b1;
                    state_next        = pcds_pkg::S_IDLE;
                end
            end
            default: begin
                state_next = pcds_pkg::S_IDLE;
            end
        endcase
    end

    `PCDS_ASSERT_NXT(a_div_to_proj, (state_reg == pcds_pkg::S_DIV) && (div_cnt_reg == pcds_pkg::DIV_CNT_W'(pcds_pkg::DIV_STEPS - 1)), state_reg == pcds_pkg::S_PROJ)
    `PCDS_ASSERT_NXT(a_behind_rejected, (state_reg == pcds_pkg::S_DECIDE) && st.is_splat && st.z_bad, state_reg == pcds_pkg::S_REJ_Z)
    `PCDS_ASSERT_NXT(a_outside_rejected, (state_reg == pcds_pkg::S_CHECK) && !st.bounds_ok, state_reg == pcds_pkg::S_REJ_B)
    `PCDS_ASSERT_IMP(a_no_accept_busy, state_reg != pcds_pkg::S_IDLE, !cmd.accept)

endmodule

// ===== design/pcds_dp.sv =====
module pcds_dp (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_we,
    input  logic [pcds_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [pcds_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  pcds_pkg::item_t                     item,
    input  pcds_pkg::cmd_t                      cmd,
    output pcds_pkg::stat_t                     st,
    output logic                                out_valid,
    input  logic                                out_ready,
    output pcds_pkg::result_t                   result
);

    localparam int AW = pcds_pkg::ADDR_W;

    // configuration registers
    logic [23:0]        focal_x_reg, focal_y_reg, center_x_reg, center_y_reg;
    logic [10:0]        width_reg;
    logic [9:0]         height_reg;
    logic               mode_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            focal_x_reg  <= 24'd153600;
            focal_y_reg  <= 24'd153600;
            center_x_reg <= 24'd81920;
            center_y_reg <= 24'd61440;
            width_reg    <= 11'd640;
            height_reg   <= 10'd480;
            mode_reg     <= 1'b0;
        end else if (cfg_we) begin
            case (pcds_pkg::cfg_idx_t'(cfg_index))
                pcds_pkg::CFG_FOCAL_X:  focal_x_reg  <= cfg_data;
                pcds_pkg::CFG_FOCAL_Y:  focal_y_reg  <= cfg_data;
                pcds_pkg::CFG_CENTER_X: center_x_reg <= cfg_data;
                pcds_pkg::CFG_CENTER_Y: center_y_reg <= cfg_data;
                pcds_pkg::CFG_WIDTH:    width_reg    <= cfg_data[10:0];
                pcds_pkg::CFG_HEIGHT:   height_reg   <= cfg_data[9:0];
                pcds_pkg::CFG_MODE:     mode_reg     <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // captured request
    pcds_pkg::item_t    item_reg;

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            item_reg <= item;
        end
    end

    logic               is_splat, is_clear;
    logic [30:0]        divisor;

    assign is_splat = item_reg.action == pcds_pkg::ACT_SPLAT;
    assign is_clear = item_reg.action == pcds_pkg::ACT_CLEAR;
    assign divisor  = item_reg.in_z[30:0];

    // products x*fx and y*fy
    logic signed [56:0] prod_reg [2];

    always_ff @(posedge aclk) begin
        if (cmd.mul) begin
            prod_reg[0] <= $signed(item_reg.in_x) * $signed({1'b0, focal_x_reg});
            prod_reg[1] <= $signed(item_reg.in_y) * $signed({1'b0, focal_y_reg});
        end
    end

    // floor division lanes: magnitude in ones complement, restoring steps
    logic               sgn_reg [2];
    logic               ovf_reg [2];
    logic [30:0]        rem_reg [2];
    logic [24:0]        low_reg [2];
    logic [24:0]        quo_reg [2];
    logic [54:0]        mag     [2];
    logic [31:0]        trial   [2];
    logic               fits    [2];

    always_comb begin
        for (int i = 0; i < 2; i++) begin
            mag[i]   = prod_reg[i][54:0] ^ {55{prod_reg[i][56]}};
            trial[i] = {rem_reg[i], low_reg[i][24]};
            fits[i]  = trial[i] >= {1'b0, divisor};
        end
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < 2; i++) begin
            if (cmd.div_init) begin
                sgn_reg[i] <= prod_reg[i][56];
                ovf_reg[i] <= {1'b0, mag[i][54:25]} >= divisor;
                rem_reg[i] <= {1'b0, mag[i][54:25]};
                low_reg[i] <= mag[i][24:0];
                quo_reg[i] <= '0;
            end else if (cmd.div_step) begin
                rem_reg[i] <= fits[i] ? 31'(trial[i] - {1'b0, divisor}) : trial[i][30:0];
                low_reg[i] <= {low_reg[i][23:0], 1'b0};
                quo_reg[i] <= {quo_reg[i][23:0], fits[i]};
            end
        end
    end

    // pixel coordinates, perspective or orthographic
    logic signed [26:0] quot    [2];
    logic signed [27:0] psum    [2];
    logic signed [32:0] osum    [2];
    logic signed [19:0] coord   [2];
    logic [23:0]        center  [2];
    logic [31:0]        pos     [2];
    logic signed [19:0] u_reg, v_reg;

    always_comb begin
        center[0] = center_x_reg;
        center[1] = center_y_reg;
        pos[0]    = item_reg.in_x;
        pos[1]    = item_reg.in_y;
        for (int i = 0; i < 2; i++) begin
            if (ovf_reg[i]) begin
                quot[i] = sgn_reg[i] ? -27'sd33554432 : 27'sd33554432;
            end else begin
                quot[i] = $signed({2'b00, quo_reg[i]} ^ {27{sgn_reg[i]}});
            end
            psum[i] = 28'(quot[i]) + 28'($signed(center[i]));
            osum[i] = 33'($signed(pos[i])) + 33'($signed({center[i], 8'h00}));
            coord[i] = mode_reg ? 20'($signed(osum[i][32:16])) : psum[i][27:8];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.proj) begin
            u_reg <= coord[0];
            v_reg <= coord[1];
        end
    end

    // bounds check and pixel index
    logic [10:0]        w_eff;
    logic [9:0]         h_eff;
    logic [19:0]        row_base;
    logic               bounds_ok_reg;
    logic [AW-1:0]      idx_reg;

    assign w_eff    = (width_reg > 11'(pcds_pkg::MAX_WIDTH)) ? 11'(pcds_pkg::MAX_WIDTH)
                                                             : width_reg;
    assign h_eff    = (height_reg > 10'(pcds_pkg::MAX_HEIGHT)) ? 10'(pcds_pkg::MAX_HEIGHT)
                                                               : height_reg;
    assign row_base = 20'(v_reg[8:0]) * 20'(w_eff);

    always_ff @(posedge aclk) begin
        if (cmd.index) begin
            bounds_ok_reg <= !u_reg[19] && !v_reg[19] && ($unsigned(u_reg) < 20'(w_eff))
                             && ($unsigned(v_reg) < 20'(h_eff));
            idx_reg       <= AW'(row_base + 20'(u_reg[9:0]));
        end
    end

    // clearing sweep after reset
    logic [AW-1:0]      sweep_cnt_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sweep_cnt_reg <= '0;
        end else if (cmd.sweep) begin
            sweep_cnt_reg <= sweep_cnt_reg + 1'b1;
        end
    end

    // pixel stores
    logic [AW-1:0]                  ram_raddr, ram_waddr;
    logic                           main_we, normal_we, color_we, zero_wr;
    logic [pcds_pkg::MAIN_W-1:0]    main_wdata, main_rdata;
    logic [pcds_pkg::NORMAL_W-1:0]  normal_wdata, normal_rdata, normal_new;
    logic [pcds_pkg::COLOR_W-1:0]   color_wdata, color_rdata;

    assign normal_new   = {item_reg.in_normal_z, item_reg.in_normal_y, item_reg.in_normal_x};
    assign ram_raddr    = is_splat ? idx_reg : item_reg.pixel_addr;
    assign zero_wr      = cmd.sweep || (cmd.commit && is_clear);
    assign ram_waddr    = cmd.sweep ? sweep_cnt_reg : ram_raddr;
    assign main_we      = zero_wr || (cmd.commit && is_splat);
    assign normal_we    = zero_wr || (cmd.commit && is_splat && item_reg.normal_present);
    assign color_we     = zero_wr || (cmd.commit && is_splat && item_reg.color_present);
    assign main_wdata   = zero_wr ? '0
                        : {item_reg.in_z[30:0], item_reg.in_y, item_reg.in_x};
    assign normal_wdata = zero_wr ? '0 : normal_new;
    assign color_wdata  = zero_wr ? '0 : item_reg.in_color;

    pcds_ram #(.WIDTH(pcds_pkg::MAIN_W), .DEPTH(pcds_pkg::PIXEL_COUNT)) u_main_ram (
        .aclk  (aclk),
        .we    (main_we),
        .waddr (ram_waddr),
        .wdata (main_wdata),
        .re    (cmd.rd),
        .raddr (ram_raddr),
        .rdata (main_rdata)
    );

    pcds_ram #(.WIDTH(pcds_pkg::NORMAL_W), .DEPTH(pcds_pkg::PIXEL_COUNT)) u_normal_ram (
        .aclk  (aclk),
        .we    (normal_we),
        .waddr (ram_waddr),
        .wdata (normal_wdata),
        .re    (cmd.rd),
        .raddr (ram_raddr),
        .rdata (normal_rdata)
    );

    pcds_ram #(.WIDTH(pcds_pkg::COLOR_W), .DEPTH(pcds_pkg::PIXEL_COUNT)) u_color_ram (
        .aclk  (aclk),
        .we    (color_we),
        .waddr (ram_waddr),
        .wdata (color_wdata),
        .re    (cmd.rd),
        .raddr (ram_raddr),
        .rdata (color_rdata)
    );

    // result assembly
    pcds_pkg::result_t  res_next, result_reg;
    logic               out_valid_reg;
    logic [pcds_pkg::NORMAL_W-1:0] normal_sel;
    logic [pcds_pkg::COLOR_W-1:0]  color_sel;

    always_comb begin
        res_next   = '0;
        normal_sel = '0;
        color_sel  = '0;
        if (cmd.reject) begin
            res_next.status = cmd.reject_bounds ? pcds_pkg::STAT_OUTSIDE
                                                : pcds_pkg::STAT_BEHIND;
        end else if (is_splat) begin
            normal_sel = item_reg.normal_present ? normal_new : normal_rdata;
            color_sel  = item_reg.color_present ? item_reg.in_color : color_rdata;
            res_next.status       = pcds_pkg::STAT_STORED;
            res_next.out_pixel    = idx_reg;
            res_next.out_x        = item_reg.in_x;
            res_next.out_y        = item_reg.in_y;
            res_next.out_depth    = item_reg.in_z[30:0];
            res_next.out_normal_x = normal_sel[15:0];
            res_next.out_normal_y = normal_sel[31:16];
            res_next.out_normal_z = normal_sel[47:32];
            res_next.out_color    = color_sel;
        end else begin
            res_next.status       = pcds_pkg::STAT_DONE;
            res_next.out_pixel    = item_reg.pixel_addr;
            res_next.out_x        = main_rdata[31:0];
            res_next.out_y        = main_rdata[63:32];
            res_next.out_depth    = main_rdata[94:64];
            res_next.out_normal_x = normal_rdata[15:0];
            res_next.out_normal_y = normal_rdata[31:16];
            res_next.out_normal_z = normal_rdata[47:32];
            res_next.out_color    = color_rdata;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.commit || cmd.reject) begin
            out_valid_reg <= 1'b1;
        end else if (out_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.commit || cmd.reject) begin
            result_reg <= res_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign result    = result_reg;

    // status to controller
    assign st.sweep_last = &sweep_cnt_reg;
    assign st.is_splat   = is_splat;
    assign st.is_ortho   = mode_reg;
    assign st.z_bad      = item_reg.in_z[31] || (item_reg.in_z == 32'd0);
    assign st.bounds_ok  = bounds_ok_reg;
    assign st.out_free   = !out_valid_reg || out_ready;

endmodule

// ===== design/point_cloud_depth_splat_unit.sv =====
// channel   direction  handshake            payload
// s_        in         s_tvalid / s_tready  s_tuser action, s_tdata point and pixel address
// m_        out        m_tvalid / m_tready  m_tuser status, m_tdata pixel contents
// cfg_      in         cfg_we               cfg_index, cfg_data
//
// one request at a time; a perspective splat runs the 25-step restoring divider,
// an orthographic splat skips it, and read, clear and behind-camera requests bypass it
// after reset a clearing pass writes zero to all 524288 pixels, one per cycle,
// while s_tready stays low; configuration writes are taken throughout
// a waiting result sits in the output register; the next request is taken meanwhile
module point_cloud_depth_splat_unit (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // in_x, in_y, in_z, in_normal_x, in_normal_y, in_normal_z, normal_present,
    // in_color, color_present, pixel_addr, zero fill
    input  logic [pcds_pkg::S_TDATA_W-1:0]      s_tdata,
    // action
    input  logic [1:0]                          s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // out_pixel, out_x, out_y, out_depth, out_normal_x, out_normal_y, out_normal_z,
    // out_color, zero fill
    output logic [pcds_pkg::M_TDATA_W-1:0]      m_tdata,
    // status
    output logic [1:0]                          m_tuser,
    input  logic                                cfg_we,
    input  logic [pcds_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [pcds_pkg::CFG_DATA_W-1:0]     cfg_data
);

    pcds_pkg::item_t    item;
    pcds_pkg::result_t  result;
    pcds_pkg::cmd_t     cmd;
    pcds_pkg::stat_t    st;

    // unpack request
    assign item.action         = s_tuser;
    assign item.in_x           = s_tdata[31:0];
    assign item.in_y           = s_tdata[63:32];
    assign item.in_z           = s_tdata[95:64];
    assign item.in_normal_x    = s_tdata[111:96];
    assign item.in_normal_y    = s_tdata[127:112];
    assign item.in_normal_z    = s_tdata[143:128];
    assign item.normal_present = s_tdata[144];
    assign item.in_color       = s_tdata[168:145];
    assign item.color_present  = s_tdata[169];
    assign item.pixel_addr     = s_tdata[188:170];

    pcds_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .st       (st),
        .cmd      (cmd)
    );

    pcds_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .item      (item),
        .cmd       (cmd),
        .st        (st),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .result    (result)
    );

    // pack result
    assign m_tuser = result.status;
    assign m_tdata = {6'd0, result.out_color, result.out_normal_z, result.out_normal_y,
                      result.out_normal_x, result.out_depth, result.out_y, result.out_x,
                      result.out_pixel};

endmodule
